// ===== hdl/assert_macros.svh =====
// Assertion helpers for the RTL.
// Both macros expect signals named clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/kerl_pkg.sv =====
package kerl_pkg;

	localparam int KEY_W   = 64;
	localparam int TICK_W  = 32;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 64;

	localparam logic [TICK_W-1:0] HOLDOFF_RESET = 32'd100;

	// register index, taken from paddr[3] (8-byte spacing)
	localparam logic REG_OWN_KEY = 1'b0;
	localparam logic REG_HOLDOFF = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0]  own_key;
		logic [TICK_W-1:0] holdoff_ticks;
	} cfg_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [TICK_W-1:0] tick;
	} slot_t;

endpackage

// ===== hdl/kerl_regs.sv =====
module kerl_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [kerl_pkg::PADDR_W-1:0]  paddr,
	input  logic [kerl_pkg::PDATA_W-1:0]  pwdata,
	output logic [kerl_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output kerl_pkg::cfg_t                cfg
);
	import kerl_pkg::*;

	logic [KEY_W-1:0]  own_key_q;
	logic [TICK_W-1:0] holdoff_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_key_q <= '0;
			holdoff_q <= HOLDOFF_RESET;
		end else if (wr_en) begin
			unique case (paddr[3])
				REG_OWN_KEY: own_key_q <= pwdata;
				REG_HOLDOFF: holdoff_q <= pwdata[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3])
			REG_OWN_KEY: prdata = own_key_q;
			REG_HOLDOFF: prdata = {{(PDATA_W-TICK_W){1'b0}}, holdoff_q};
			default:     prdata = '0;
		endcase
	end

	assign cfg.own_key       = own_key_q;
	assign cfg.holdoff_ticks = holdoff_q;

endmodule

// ===== hdl/kerl_slot_ram.sv =====
module kerl_slot_ram #(
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  kerl_pkg::slot_t          wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output kerl_pkg::slot_t          rdata
);
	import kerl_pkg::*;

	slot_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/keyed_event_rate_limiter_core.sv =====
// Keyed event rate limiter: drops repeats of one key that come within a tick holdoff.
// Input channel (in_valid/in_ready): event_key, now_tick, exempt_key per request.
// Output channel (out_valid/out_ready): forward and table_written, one per request.
// Keys of zero, own_key or exempt_key always forward and leave the table alone;
// other keys are folded to a slot of a direct-mapped key/tick table.
// Config over the APB port: own_key at 0x0, holdoff_ticks at 0x8, 64-bit data.
// One request is in flight at a time. A table request passes through the
// reciprocal multiply, the quotient multiply, the remainder fix and RAM read, and the
// lookup/write-back; out_valid rises as it leaves the lookup, and in_ready returns
// with it. Exempt keys skip the table, going straight from the reciprocal multiply
// step to the lookup. The cost is set by the slot index (fold mod TABLE_DEPTH)
// chain and the read-modify-write of the slot RAM.
// The result sits in an output register; a stalled receiver holds it there and the
// next request may be accepted, but its result waits in the lookup stage (the RAM
// read data is held) until the register frees.
// After reset the table is cleared one slot per cycle, with in_ready low
// throughout. Register writes are taken during the clear.
`include "assert_macros.svh"

module keyed_event_rate_limiter_core #(
	parameter int TABLE_DEPTH = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [kerl_pkg::PADDR_W-1:0]  paddr,
	input  logic [kerl_pkg::PDATA_W-1:0]  pwdata,
	output logic [kerl_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [kerl_pkg::KEY_W-1:0]    event_key,
	input  logic [kerl_pkg::TICK_W-1:0]   now_tick,
	input  logic [kerl_pkg::KEY_W-1:0]    exempt_key,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          forward,
	output logic                          table_written
);
	import kerl_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
	localparam logic [TICK_W-1:0] DEPTH_C  = TICK_W'(TABLE_DEPTH);
	// floor(2^32 / depth): estimated quotient is low by at most one
	localparam logic [TICK_W-1:0] RECIP    = TICK_W'((64'd1 << 32) / TABLE_DEPTH);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_QMUL  = 3'd3;
	localparam logic [2:0] ST_FIX   = 3'd4;
	localparam logic [2:0] ST_LOOK  = 3'd5;

	cfg_t              cfg;
	logic [2:0]        state_q;
	logic [IDX_W-1:0]  clr_q;
	logic [KEY_W-1:0]  key_q;
	logic [TICK_W-1:0] now_q;
	logic              bypass_q;
	logic [TICK_W-1:0] fold_q;
	logic [63:0]       prod_q;
	logic [TICK_W-1:0] qd_q;
	logic [IDX_W-1:0]  idx_q;
	logic              out_valid_q;
	logic              forward_q;
	logic              written_q;

	logic [TICK_W-1:0] rem_raw;
	logic [TICK_W-1:0] rem_c;
	logic [IDX_W-1:0]  idx_c;
	logic              accept;
	logic              can_emit;
	logic              hit;
	logic              do_write;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	slot_t             mem_wdata;
	slot_t             rd_slot;

	kerl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	kerl_slot_ram #(.DEPTH(TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (state_q == ST_FIX),
		.raddr (idx_c),
		.rdata (rd_slot)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign can_emit = !out_valid_q || out_ready;

	// remainder from the estimated quotient is below twice the depth
	assign rem_raw = fold_q - qd_q;
	assign rem_c   = (rem_raw >= DEPTH_C) ? (rem_raw - DEPTH_C) : rem_raw;
	assign idx_c   = rem_c[IDX_W-1:0];

	assign hit = (rd_slot.key == key_q) && ((now_q - rd_slot.tick) < cfg.holdoff_ticks);
	assign do_write = !bypass_q && !hit;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = '{key: key_q, tick: now_q};
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (state_q == ST_LOOK) begin
			mem_we = can_emit && do_write;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: if (accept) state_q <= ST_MUL;
				ST_MUL:  state_q <= bypass_q ? ST_LOOK : ST_QMUL;
				ST_QMUL: state_q <= ST_FIX;
				ST_FIX:  state_q <= ST_LOOK;
				ST_LOOK: if (can_emit) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q    <= event_key;
			now_q    <= now_tick;
			fold_q   <= event_key[31:0] ^ event_key[63:32];
			bypass_q <= (event_key == '0) || (event_key == cfg.own_key)
				|| (event_key == exempt_key);
		end
		if (state_q == ST_MUL) begin
			prod_q <= 64'(fold_q) * 64'(RECIP);
		end
		if (state_q == ST_QMUL) begin
			qd_q <= TICK_W'(prod_q[63:32] * DEPTH_C);
		end
		if (state_q == ST_FIX) begin
			idx_q <= idx_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_LOOK && can_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOOK && can_emit) begin
			forward_q <= bypass_q || !hit;
			written_q <= do_write;
		end
	end

	assign out_valid     = out_valid_q;
	assign forward       = forward_q;
	assign table_written = written_q;

	`ASSERT_IMP(a_written_implies_fwd, out_valid_q, forward_q || !written_q, "dropped but written")
	`ASSERT_IMP(a_we_states, mem_we, state_q == ST_CLEAR || state_q == ST_LOOK, "stray RAM write")
	`ASSERT_IMP(a_bypass_no_write, state_q == ST_LOOK && bypass_q, !mem_we, "exempt key write")
	`ASSERT_NEXT(a_single_flight, accept, !in_ready, "overlapping requests")

endmodule

// ===== sim/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kerl_pkg::*;

	localparam int DEPTH = 512;
	localparam int RANDOM_PER_PHASE = 105;

	typedef struct packed {
		logic fwd;
		logic written;
	} verdict_t;

	// how a stimulus row gets its expected verdict
	typedef enum logic [1:0] {V_PRED, V_PASS, V_WRITE, V_DROP} verdict_e;
	typedef enum logic [1:0] {ROW_EVENT, ROW_OWN_KEY, ROW_HOLDOFF} row_kind_e;

	typedef struct {
		row_kind_e         kind;
		logic [KEY_W-1:0]  key;
		logic [TICK_W-1:0] tick;
		logic [KEY_W-1:0]  exempt;
		verdict_e          verdict;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [KEY_W-1:0] event_key = '0;
	logic [TICK_W-1:0] now_tick = '0;
	logic [KEY_W-1:0] exempt_key = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic forward;
	logic table_written;

	keyed_event_rate_limiter_core #(.TABLE_DEPTH(DEPTH)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.event_key(event_key), .now_tick(now_tick), .exempt_key(exempt_key),
		.out_valid(out_valid), .out_ready(out_ready),
		.forward(forward), .table_written(table_written)
	);

	always #5 clk = ~clk;

	// shadow of the block's registers and slot table
	logic [KEY_W-1:0]  own_key_m = '0;
	logic [TICK_W-1:0] holdoff_m = HOLDOFF_RESET;
	logic [KEY_W-1:0]  slot_key_m [DEPTH];
	logic [TICK_W-1:0] slot_tick_m [DEPTH];

	verdict_t verdict_q[$];
	row_t plan[$];
	int mismatches = 0;
	int unsigned burst_left = 0;
	int unsigned ready_cycle = 0;

	function automatic verdict_t limit_event(input logic [KEY_W-1:0] key,
			input logic [TICK_W-1:0] tick, input logic [KEY_W-1:0] exempt);
		int unsigned idx;
		logic [TICK_W-1:0] tick_gap;
		if (key == '0 || key == own_key_m || key == exempt)
			return '{fwd: 1'b1, written: 1'b0};
		idx = (key[31:0] ^ key[63:32]) % DEPTH;
		tick_gap = tick - slot_tick_m[idx];
		if (slot_key_m[idx] == key && tick_gap < holdoff_m)
			return '{fwd: 1'b0, written: 1'b0};
		slot_key_m[idx] = key;
		slot_tick_m[idx] = tick;
		return '{fwd: 1'b1, written: 1'b1};
	endfunction

	function automatic logic [KEY_W-1:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	function automatic row_t ev(input logic [KEY_W-1:0] key, input logic [TICK_W-1:0] tick,
			input logic [KEY_W-1:0] exempt, input verdict_e verdict);
		return '{kind: ROW_EVENT, key: key, tick: tick, exempt: exempt, verdict: verdict};
	endfunction

	function automatic row_t cfg(input row_kind_e kind, input logic [KEY_W-1:0] value);
		return '{kind: kind, key: value, tick: '0, exempt: '0, verdict: V_PRED};
	endfunction

	task automatic send_event(input logic [KEY_W-1:0] key, input logic [TICK_W-1:0] tick,
			input logic [KEY_W-1:0] exempt, input verdict_e verdict);
		verdict_t v;
		int unsigned gap;
		v = limit_event(key, tick, exempt);
		case (verdict)
			V_PASS:  v = '{fwd: 1'b1, written: 1'b0};
			V_WRITE: v = '{fwd: 1'b1, written: 1'b1};
			V_DROP:  v = '{fwd: 1'b0, written: 1'b0};
			default: ;
		endcase
		verdict_q.push_back(v);
		in_valid <= 1'b1;
		event_key <= key;
		now_tick <= tick;
		exempt_key <= exempt;
		do @(posedge clk); while (!in_ready);
		if (burst_left != 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 15);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			// valid is only lowered when a real gap follows
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// hold requests back until every verdict is in and the pipe has emptied
	task automatic settle();
		in_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_reg(input logic idx, input logic [PDATA_W-1:0] value);
		settle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_OWN_KEY)
			own_key_m = value;
		else
			holdoff_m = value[TICK_W-1:0];
	endtask

	// keys mostly from a small pool so that repeats hit the holdoff window
	task automatic run_random(input int unsigned n, input logic [TICK_W-1:0] start);
		logic [KEY_W-1:0] pool [6];
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] exempt;
		logic [TICK_W-1:0] tick;
		int unsigned pick;
		int unsigned step;
		tick = start;
		foreach (pool[k])
			pool[k] = rand_key();
		// same slot, different key
		pool[1] = pool[0] ^ (64'($urandom_range(1, 255)) << 9);
		for (int unsigned i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			key = pool[$urandom_range(0, 5)];
			exempt = rand_key();
			if (pick >= 70 && pick < 78)
				key = own_key_m;
			else if (pick >= 78 && pick < 83)
				key = '0;
			else if (pick >= 83 && pick < 93)
				exempt = key;
			else if (pick >= 93)
				key = rand_key();
			step = $urandom_range(0, 99);
			if (step < 90)
				tick = tick + $urandom_range(0, 30);
			else if (step < 97)
				tick = tick + $urandom_range(0, 400);
			else
				tick = $urandom;
			send_event(key, tick, exempt, V_PRED);
		end
	endtask

	// receiver stall pattern, stepping through four modes on ready_cycle[7:6]
	always @(posedge clk) begin
		ready_cycle <= ready_cycle + 1;
		case (ready_cycle[7:6])
			2'd0: out_ready <= 1'b1;
			2'd1: out_ready <= ($urandom_range(0, 1) == 1);
			2'd2: out_ready <= (ready_cycle[2:0] != 3'd0);
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(posedge clk) begin
		verdict_t exp_v;
		if (arst_n && out_valid && out_ready) begin
			if (verdict_q.size() == 0) begin
				$error("result with nothing expected: forward %0b table_written %0b",
					forward, table_written);
				mismatches++;
			end else begin
				exp_v = verdict_q.pop_front();
				if (forward !== exp_v.fwd) begin
					$error("forward: expected %0b, got %0b", exp_v.fwd, forward);
					mismatches++;
				end
				if (table_written !== exp_v.written) begin
					$error("table_written: expected %0b, got %0b", exp_v.written, table_written);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		foreach (slot_key_m[i]) begin
			slot_key_m[i] = '0;
			slot_tick_m[i] = '0;
		end

		plan.push_back(cfg(ROW_OWN_KEY, 64'h0123_4567_89AB_CDEF));
		plan.push_back(ev(64'h0, 32'h0, 64'h0, V_PASS));
		plan.push_back(ev(64'h0123_4567_89AB_CDEF, 32'd5, 64'h7, V_PASS));
		plan.push_back(ev('1, 32'd9, '1, V_PASS));
		plan.push_back(ev(64'd5, 32'd1000, 64'h0, V_WRITE));
		plan.push_back(ev(64'd5, 32'd1050, 64'h0, V_DROP));
		plan.push_back(ev(64'd5, 32'd1099, 64'h0, V_DROP));
		plan.push_back(ev(64'd5, 32'd1100, 64'h0, V_WRITE));
		// tick went backwards: huge distance
		plan.push_back(ev(64'd5, 32'd50, 64'h0, V_WRITE));
		plan.push_back(ev(64'd517, 32'd60, 64'h0, V_PRED));
		plan.push_back(ev(64'd5, 32'd61, 64'h0, V_PRED));
		plan.push_back(ev(64'd5, 32'd61, 64'd5, V_PASS));
		plan.push_back(ev('1, '1, 64'h0, V_WRITE));
		// distance wraps through zero: 99 then 100
		plan.push_back(ev('1, 32'h62, 64'h0, V_DROP));
		plan.push_back(ev('1, 32'h63, 64'h0, V_WRITE));
		plan.push_back(ev(64'h0000_0001_0000_0000, 32'd7, 64'h0, V_WRITE));
		plan.push_back(ev(64'h0000_0001_0000_0000, 32'd8, 64'h0, V_DROP));
		plan.push_back(ev(64'd1, 32'd8, 64'h0, V_PRED));
		plan.push_back(cfg(ROW_HOLDOFF, 64'h0));
		plan.push_back(ev(64'd1, 32'd8, 64'h0, V_WRITE));
		plan.push_back(ev(64'd1, 32'd8, 64'h0, V_WRITE));
		plan.push_back(cfg(ROW_HOLDOFF, 64'hFFFF_FFFF));
		plan.push_back(ev(64'd1, 32'd0, 64'h0, V_DROP));
		plan.push_back(ev(64'd1, 32'd7, 64'h0, V_WRITE));
		plan.push_back(ev(64'd1, 32'd7, 64'h0, V_DROP));
		plan.push_back(cfg(ROW_OWN_KEY, '1));
		plan.push_back(ev('1, 32'd3, 64'h1, V_PASS));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[r]) begin
			case (plan[r].kind)
				ROW_OWN_KEY: set_reg(REG_OWN_KEY, plan[r].key);
				ROW_HOLDOFF: set_reg(REG_HOLDOFF, plan[r].key);
				default: send_event(plan[r].key, plan[r].tick, plan[r].exempt, plan[r].verdict);
			endcase
		end

		set_reg(REG_OWN_KEY, rand_key());
		set_reg(REG_HOLDOFF, 64'(HOLDOFF_RESET));
		run_random(RANDOM_PER_PHASE, $urandom);

		set_reg(REG_OWN_KEY, '1);
		set_reg(REG_HOLDOFF, 64'h0);
		run_random(RANDOM_PER_PHASE, 32'hFFFF_FF00);

		set_reg(REG_OWN_KEY, 64'h0);
		set_reg(REG_HOLDOFF, 64'hFFFF_FFFF);
		run_random(RANDOM_PER_PHASE, $urandom);

		set_reg(REG_OWN_KEY, rand_key());
		set_reg(REG_HOLDOFF, 64'($urandom_range(1, 200)));
		run_random(RANDOM_PER_PHASE, $urandom);

		set_reg(REG_OWN_KEY, rand_key());
		set_reg(REG_HOLDOFF, 64'($urandom));
		run_random(RANDOM_PER_PHASE, $urandom);

		settle();
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
